// ----- src/hsv2rgb_pkg.sv -----
// shared types, constants and sector codes for the hsv to rgb converter
package hsv2rgb_pkg;

   // channel format: all ones means full scale
   localparam int CH_BITS = 8;
   localparam logic [CH_BITS-1:0] CH_MAX = '1;

   // hue: degrees with 8 fraction bits
   localparam int HUE_BITS = 17;
   localparam int FRAC_BITS = 8;
   localparam logic [HUE_BITS-1:0] HUE_FULL = 17'd92160;
   localparam logic [HUE_BITS-1:0] HUE_SECTOR = 17'd15360;

   // remainder within a sector, and the remainder over four
   localparam int REM_BITS = 14;
   localparam int DEG_SHIFT = 2;
   localparam int QUART_BITS = REM_BITS - DEG_SHIFT;

   // x / 15 as (x * 4369) >> 16 plus one correction step
   localparam int FRAC_DIV = 15;
   localparam int RECIP_BITS = 13;
   localparam logic [RECIP_BITS-1:0] RECIP15 = 13'd4369;
   localparam int RECIP_SHIFT = 16;

   // scaled saturation terms and products
   localparam int SCALE_BITS = CH_BITS + FRAC_BITS;
   localparam logic [SCALE_BITS-1:0] SCALE_ONE = {CH_MAX, {FRAC_BITS{1'b0}}};
   localparam int PROD_BITS = 2 * CH_BITS;

   typedef logic [CH_BITS-1:0] chan_type;

   typedef enum logic [2:0] {
      SECT_RY = 3'd0,
      SECT_YG = 3'd1,
      SECT_GC = 3'd2,
      SECT_CB = 3'd3,
      SECT_BM = 3'd4,
      SECT_MR = 3'd5
   } sector_type;

   // hue split result: sector, fraction and the channel inputs
   typedef struct packed {
      sector_type             sector;
      logic [FRAC_BITS-1:0]   frac;
      chan_type               sat;
      chan_type               val;
   } split_type;

   // scaled intermediates ready for channel routing
   typedef struct packed {
      sector_type sector;
      chan_type   sat;
      chan_type   val;
      chan_type   p;
      chan_type   q;
      chan_type   t;
   } pqt_type;

endpackage

// ----- src/hsv2rgb_if.sv -----
// valid/ready channel interfaces for hsv pixels in and rgb pixels out
interface hsv2rgb_hsv_if import hsv2rgb_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [HUE_BITS-1:0] hue;
   chan_type            saturation;
   chan_type            brightness;

   modport source(output valid, hue, saturation, brightness, input ready);
   modport sink(input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv2rgb_rgb_if import hsv2rgb_pkg::*; ();
   logic     valid;
   logic     ready;
   chan_type red;
   chan_type green;
   chan_type blue;

   modport source(output valid, red, green, blue, input ready);
   modport sink(input valid, red, green, blue, output ready);
endinterface

// ----- src/hsv2rgb_hue_split.sv -----
// three-stage hue split: range wrap and sector, then fraction by reciprocal multiply
module hsv2rgb_hue_split import hsv2rgb_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [HUE_BITS-1:0] in_hue,
   input  chan_type            in_sat,
   input  chan_type            in_val,
   output logic                out_valid,
   input  logic                out_ready,
   output split_type           out_data
);

   logic st1_valid_ff, st2_valid_ff, st3_valid_ff;
   logic st1_en, st2_en, st3_en;

   // stage 1 registers
   sector_type            st1_sector_ff, st1_sector_in;
   logic [REM_BITS-1:0]   st1_rem_ff, st1_rem_in;
   chan_type              st1_sat_ff, st1_val_ff;

   // stage 2 registers
   sector_type            st2_sector_ff;
   logic [QUART_BITS-1:0] st2_quart_ff, st2_quart_in;
   logic [FRAC_BITS-1:0]  st2_q0_ff, st2_q0_in;
   chan_type              st2_sat_ff, st2_val_ff;

   // stage 3 registers
   split_type             st3_data_ff, st3_data_in;

   assign st3_en   = !st3_valid_ff || out_ready;
   assign st2_en   = !st2_valid_ff || st3_en;
   assign st1_en   = !st1_valid_ff || st2_en;
   assign in_ready = st1_en;

   // out-of-range hue wraps to zero, then pick sector and base
   always_comb begin
      logic [HUE_BITS-1:0] hue_w;
      logic [HUE_BITS-1:0] base;
      hue_w = (in_hue >= HUE_FULL) ? '0 : in_hue;
      priority if (hue_w < HUE_SECTOR) begin
         st1_sector_in = SECT_RY;
         base          = '0;
      end else if (hue_w < HUE_BITS'(2 * HUE_SECTOR)) begin
         st1_sector_in = SECT_YG;
         base          = HUE_SECTOR;
      end else if (hue_w < HUE_BITS'(3 * HUE_SECTOR)) begin
         st1_sector_in = SECT_GC;
         base          = HUE_BITS'(2 * HUE_SECTOR);
      end else if (hue_w < HUE_BITS'(4 * HUE_SECTOR)) begin
         st1_sector_in = SECT_CB;
         base          = HUE_BITS'(3 * HUE_SECTOR);
      end else if (hue_w < HUE_BITS'(5 * HUE_SECTOR)) begin
         st1_sector_in = SECT_BM;
         base          = HUE_BITS'(4 * HUE_SECTOR);
      end else begin
         st1_sector_in = SECT_MR;
         base          = HUE_BITS'(5 * HUE_SECTOR);
      end
      st1_rem_in = REM_BITS'(hue_w - base);
   end

   // rem / 60 = (rem / 4) / 15, estimate by reciprocal
   always_comb begin
      logic [QUART_BITS+RECIP_BITS-1:0] prod;
      st2_quart_in = st1_rem_ff[REM_BITS-1:DEG_SHIFT];
      prod         = st2_quart_in * RECIP15;
      st2_q0_in    = prod[RECIP_SHIFT+FRAC_BITS-1:RECIP_SHIFT];
   end

   // estimate is low by at most one
   always_comb begin
      logic [QUART_BITS-1:0] back;
      logic [QUART_BITS-1:0] resid;
      back   = QUART_BITS'(st2_q0_ff) * QUART_BITS'(FRAC_DIV);
      resid  = st2_quart_ff - back;
      st3_data_in.sector = st2_sector_ff;
      st3_data_in.frac   = st2_q0_ff + FRAC_BITS'(resid >= QUART_BITS'(FRAC_DIV));
      st3_data_in.sat    = st2_sat_ff;
      st3_data_in.val    = st2_val_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_valid_ff <= 1'b0;
         st2_valid_ff <= 1'b0;
         st3_valid_ff <= 1'b0;
      end else begin
         if (st1_en) st1_valid_ff <= in_valid;
         if (st2_en) st2_valid_ff <= st1_valid_ff;
         if (st3_en) st3_valid_ff <= st2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (st1_en) begin
         st1_sector_ff <= st1_sector_in;
         st1_rem_ff    <= st1_rem_in;
         st1_sat_ff    <= in_sat;
         st1_val_ff    <= in_val;
      end
      if (st2_en) begin
         st2_sector_ff <= st1_sector_ff;
         st2_quart_ff  <= st2_quart_in;
         st2_q0_ff     <= st2_q0_in;
         st2_sat_ff    <= st1_sat_ff;
         st2_val_ff    <= st1_val_ff;
      end
      if (st3_en) begin
         st3_data_ff <= st3_data_in;
      end
   end

   assign out_valid = st3_valid_ff;
   assign out_data  = st3_data_ff;

endmodule

// ----- src/hsv2rgb_scale.sv -----
// three-stage p/q/t scaling: saturation products, value products, divide by full scale
module hsv2rgb_scale import hsv2rgb_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  split_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output pqt_type   out_data
);

   // floor(y / CH_MAX) for y up to CH_MAX squared, one correction step
   function automatic chan_type div_by_max(input logic [PROD_BITS-1:0] y);
      logic [PROD_BITS:0]   acc;
      logic [CH_BITS:0]     q0;
      logic [PROD_BITS-1:0] back;
      logic [PROD_BITS-1:0] resid;
      acc   = {1'b0, y} + (PROD_BITS+1)'(y >> CH_BITS);
      q0    = acc[PROD_BITS:CH_BITS];
      back  = (PROD_BITS'(q0) << CH_BITS) - PROD_BITS'(q0);
      resid = y - back;
      return CH_BITS'(q0) + CH_BITS'(resid >= PROD_BITS'(CH_MAX));
   endfunction

   logic st4_valid_ff, st5_valid_ff, st6_valid_ff;
   logic st4_en, st5_en, st6_en;

   // stage 4 registers
   sector_type            st4_sector_ff;
   chan_type              st4_sat_ff, st4_val_ff;
   logic [SCALE_BITS-1:0] st4_sf_ff, st4_sf_in;
   logic [SCALE_BITS-1:0] st4_st_ff, st4_st_in;
   logic [PROD_BITS-1:0]  st4_pm_ff, st4_pm_in;

   // stage 5 registers
   sector_type            st5_sector_ff;
   chan_type              st5_sat_ff, st5_val_ff;
   logic [PROD_BITS-1:0]  st5_yq_ff, st5_yq_in;
   logic [PROD_BITS-1:0]  st5_yt_ff, st5_yt_in;
   logic [PROD_BITS-1:0]  st5_pm_ff;

   // stage 6 registers
   pqt_type               st6_data_ff, st6_data_in;

   assign st6_en   = !st6_valid_ff || out_ready;
   assign st5_en   = !st5_valid_ff || st6_en;
   assign st4_en   = !st4_valid_ff || st5_en;
   assign in_ready = st4_en;

   // s*f, s*(256-f) and v*(max-s)
   always_comb begin
      logic [FRAC_BITS:0]          comp;
      logic [CH_BITS+FRAC_BITS:0]  st_full;
      comp      = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, in_data.frac};
      st4_sf_in = in_data.sat * in_data.frac;
      st_full   = in_data.sat * comp;
      st4_st_in = st_full[SCALE_BITS-1:0];
      st4_pm_in = in_data.val * (CH_MAX - in_data.sat);
   end

   // v times the scaled complement, fraction bits dropped
   always_comb begin
      logic [CH_BITS+SCALE_BITS-1:0] q_full;
      logic [CH_BITS+SCALE_BITS-1:0] t_full;
      q_full    = st4_val_ff * (SCALE_ONE - st4_sf_ff);
      t_full    = st4_val_ff * (SCALE_ONE - st4_st_ff);
      st5_yq_in = q_full[CH_BITS+SCALE_BITS-1:FRAC_BITS];
      st5_yt_in = t_full[CH_BITS+SCALE_BITS-1:FRAC_BITS];
   end

   always_comb begin
      st6_data_in.sector = st5_sector_ff;
      st6_data_in.sat    = st5_sat_ff;
      st6_data_in.val    = st5_val_ff;
      st6_data_in.p      = div_by_max(st5_pm_ff);
      st6_data_in.q      = div_by_max(st5_yq_ff);
      st6_data_in.t      = div_by_max(st5_yt_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st4_valid_ff <= 1'b0;
         st5_valid_ff <= 1'b0;
         st6_valid_ff <= 1'b0;
      end else begin
         if (st4_en) st4_valid_ff <= in_valid;
         if (st5_en) st5_valid_ff <= st4_valid_ff;
         if (st6_en) st6_valid_ff <= st5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (st4_en) begin
         st4_sector_ff <= in_data.sector;
         st4_sat_ff    <= in_data.sat;
         st4_val_ff    <= in_data.val;
         st4_sf_ff     <= st4_sf_in;
         st4_st_ff     <= st4_st_in;
         st4_pm_ff     <= st4_pm_in;
      end
      if (st5_en) begin
         st5_sector_ff <= st4_sector_ff;
         st5_sat_ff    <= st4_sat_ff;
         st5_val_ff    <= st4_val_ff;
         st5_yq_ff     <= st5_yq_in;
         st5_yt_ff     <= st5_yt_in;
         st5_pm_ff     <= st4_pm_ff;
      end
      if (st6_en) begin
         st6_data_ff <= st6_data_in;
      end
   end

   assign out_valid = st6_valid_ff;
   assign out_data  = st6_data_ff;

endmodule

// ----- src/hsv_to_rgb_converter.sv -----
// hsv to rgb pixel converter top level: seven-stage pipeline with output register
//
//   channel | port    | direction | beat contents
//   --------+---------+-----------+-----------------------------------------
//   input   | req_bus | sink      | hue (17b, deg * 256), saturation, brightness
//   result  | rsp_bus | source    | red, green, blue (8b each)
//
// one pixel enters per clock and one rgb beat leaves per clock when the
// result side keeps ready high
// seven register stages: sector split, fraction estimate, fraction fix,
// saturation products, value products, divide by full scale, channel routing
// each stage holds its beat while the next one is full and stalled; an empty
// stage takes a beat even when later stages stall, so bubbles get squeezed out
// req_bus.ready is combinational from rsp_bus.ready through the stage enables
// synchronous reset clears all valid bits; payload registers are not reset
module hsv_to_rgb_converter import hsv2rgb_pkg::*; (
   input logic           clock,
   input logic           reset,
   hsv2rgb_hsv_if.sink   req_bus,
   hsv2rgb_rgb_if.source rsp_bus
);

   // hue split to scaling
   logic      split_valid;
   logic      split_ready;
   split_type split_data;

   // scaling to output stage
   logic      pqt_valid;
   logic      pqt_ready;
   pqt_type   pqt_data;

   // output register
   logic      rsp_valid_ff;
   logic      out_en;
   chan_type  red_ff, red_in;
   chan_type  green_ff, green_in;
   chan_type  blue_ff, blue_in;

   // stages 1-3: wrap, sector, fraction
   hsv2rgb_hue_split u_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_hue    (req_bus.hue),
      .in_sat    (req_bus.saturation),
      .in_val    (req_bus.brightness),
      .out_valid (split_valid),
      .out_ready (split_ready),
      .out_data  (split_data)
   );

   // stages 4-6: p, q and t
   hsv2rgb_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (split_valid),
      .in_ready  (split_ready),
      .in_data   (split_data),
      .out_valid (pqt_valid),
      .out_ready (pqt_ready),
      .out_data  (pqt_data)
   );

   // stage 7: output register doubles as the skid between pipe and consumer
   assign out_en    = !rsp_valid_ff || rsp_bus.ready;
   assign pqt_ready = out_en;

   // route v, p, q, t per sector; zero saturation gives gray
   always_comb begin
      if (pqt_data.sat == '0) begin
         red_in   = pqt_data.val;
         green_in = pqt_data.val;
         blue_in  = pqt_data.val;
      end else begin
         unique case (pqt_data.sector)
            SECT_RY: begin
               red_in   = pqt_data.val;
               green_in = pqt_data.t;
               blue_in  = pqt_data.p;
            end
            SECT_YG: begin
               red_in   = pqt_data.q;
               green_in = pqt_data.val;
               blue_in  = pqt_data.p;
            end
            SECT_GC: begin
               red_in   = pqt_data.p;
               green_in = pqt_data.val;
               blue_in  = pqt_data.t;
            end
            SECT_CB: begin
               red_in   = pqt_data.p;
               green_in = pqt_data.q;
               blue_in  = pqt_data.val;
            end
            SECT_BM: begin
               red_in   = pqt_data.t;
               green_in = pqt_data.p;
               blue_in  = pqt_data.val;
            end
            default: begin
               // magenta-red sector and unused codes
               red_in   = pqt_data.val;
               green_in = pqt_data.p;
               blue_in  = pqt_data.q;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= pqt_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.red   = red_ff;
   assign rsp_bus.green = green_ff;
   assign rsp_bus.blue  = blue_ff;

endmodule

// ----- src/hsv2rgb_checker.sv -----
// port-level checks for the hsv to rgb converter and their bind
module hsv2rgb_checker import hsv2rgb_pkg::*; (
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_ready,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input chan_type rsp_red,
   input chan_type rsp_green,
   input chan_type rsp_blue
);

   localparam int PIPE_DEPTH = 7;

   logic [3:0] outstanding_ff, outstanding_in;
   logic       req_fire, rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      outstanding_in = outstanding_ff;
      if (req_fire && !rsp_fire) outstanding_in = outstanding_ff + 4'd1;
      if (rsp_fire && !req_fire) outstanding_in = outstanding_ff - 4'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   // reset empties the pipe
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red)
                                  && $stable(rsp_green) && $stable(rsp_blue))
      else $error("stalled rsp beat changed");

   // no result without an accepted pixel behind it
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outstanding_ff != 4'd0)
      else $error("rsp beat with no pixel in flight");

   // never more pixels in flight than pipeline stages
   a_depth: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= 4'(PIPE_DEPTH))
      else $error("more pixels in flight than stages");

   // a stalled full pipe takes no new pixel
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff == 4'(PIPE_DEPTH) && !rsp_ready |-> !req_ready)
      else $error("full pipe accepted a pixel while stalled");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_red   (rsp_bus.red),
   .rsp_green (rsp_bus.green),
   .rsp_blue  (rsp_bus.blue)
);
